// ----- src/sweep_range_table_closest_unit_defines.svh -----
// assertion helpers used by the rtl unit
`ifndef SWEEP_RANGE_TABLE_CLOSEST_UNIT_DEFINES_SVH
`define SWEEP_RANGE_TABLE_CLOSEST_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SRTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srtc assertion failed");

// next-cycle implication, off during reset
`define SRTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srtc assertion failed");

`endif

// ----- src/srtc_pkg.sv -----
package srtc_pkg;

  localparam int STEP  = 5;
  localparam int SLOTS = 64;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ANGLE_W   = 8;
  localparam int DIST_W    = 14;
  localparam int RANGE_W   = 13;
  localparam int STATUS_W  = 4;
  localparam int ACTION_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 14;

  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RECORD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 2'd2;

  localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE = 8'd0;
  localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE = 8'd180;
  localparam logic [DIST_W-1:0]  RST_MAX_DIST  = 14'd8190;
  localparam logic [ANGLE_W-1:0] RST_ANGLE     = 8'd90;

  localparam logic [STATUS_W-1:0] STATUS_PHASE_FAIL = 4'd4;
  localparam logic [DIST_W-1:0]   RANGE_OFFSET      = 14'd15;

  localparam logic [ANGLE_W-1:0] STEP_ANGLE = ANGLE_W'(STEP);

  // slot index by reciprocal multiply, exact for any 8-bit offset
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = ANGLE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] STEP_RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + STEP - 1) / STEP);

  typedef struct packed {
    logic [DIST_W-1:0]  range_mm;
    logic [ANGLE_W-1:0] angle;
  } slot_t;

endpackage

// ----- src/srtc_in_if.sv -----
interface srtc_in_if;
  import srtc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [RANGE_W-1:0]  raw_range;
  logic [STATUS_W-1:0] range_status;

  modport source (output valid, output action, output raw_range, output range_status,
                  input ready);
  modport sink (input valid, input action, input raw_range, input range_status,
                output ready);
endinterface

// ----- src/srtc_out_if.sv -----
interface srtc_out_if;
  import srtc_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic [DIST_W-1:0]  closest_distance;
  logic [ANGLE_W-1:0] closest_angle;

  modport source (output valid, output angle, output closest_distance,
                  output closest_angle, input ready);
  modport sink (input valid, input angle, input closest_distance, input closest_angle,
                output ready);
endinterface

// ----- src/sweep_range_table_closest_unit.sv -----
// Sweep angle tracker with a per-slot range table and a closest-object search.
// item channel: one beat carries action (advance, record, clear), raw_range and
// range_status. result channel: one beat per item with the angle after the item,
// the smallest stored distance below the far limit and the angle of its slot.
// Configuration: cfg_we, cfg_index, cfg_data write the lower and upper sweep bounds
// and the far limit; write them only while no item is in flight.
// Each item runs the action, then one table walk reads one slot per cycle from the
// slot memory through a single comparator; a new item is taken only once the result
// register is loaded and the block is back in idle.
// item.ready is high only while the block is idle.
// Reset sets angle 90, upward sweep, default registers and marks every slot as
// holding the far limit; a clear marks every slot the same way, so no sweep is needed.
// A stalled result holds its register; the block finishes the walk and then waits
// before loading the next result.
`include "sweep_range_table_closest_unit_defines.svh"

module sweep_range_table_closest_unit (
  input  logic                            clk,
  input  logic                            rst,
  srtc_in_if.sink                         item,
  srtc_out_if.source                      result,
  input  logic                            cfg_we,
  input  logic [srtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srtc_pkg::CFG_W-1:0]      cfg_data
);
  import srtc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [ANGLE_W-1:0] lo_angle;
  logic [ANGLE_W-1:0] hi_angle;
  logic [DIST_W-1:0]  far_limit;

  logic [ANGLE_W-1:0] cur_angle;
  logic               sweep_down;
  logic [DIST_W-1:0]  fill_dist;
  logic [ANGLE_W-1:0] fill_min;
  logic [SLOTS-1:0]   slot_valid;

  logic [ACTION_W-1:0] op_action;
  logic [RANGE_W-1:0]  op_range;
  logic [STATUS_W-1:0] op_status;

  logic [SLOT_W-1:0]  cnt;
  logic [ANGLE_W-1:0] nom_angle;

  slot_t              mem [SLOTS];
  slot_t              rd_slot;
  logic               rd_valid;
  logic [ANGLE_W-1:0] rd_nom;
  logic               cmp_en;

  logic [DIST_W-1:0]  best_dist;
  logic [ANGLE_W-1:0] best_angle;

  logic               res_valid;
  logic [ANGLE_W-1:0] res_angle;
  logic [DIST_W-1:0]  res_dist;
  logic [ANGLE_W-1:0] res_best_angle;

  logic               accept;
  logic               load;
  logic [ANGLE_W-1:0] diff;
  logic [PROD_W-1:0]  prod;
  logic [ANGLE_W-1:0] slot_idx;
  logic               rec_ok;
  logic [DIST_W-1:0]  rec_dist;
  logic               do_write;
  logic [SLOT_W-1:0]  wr_addr;
  logic               at_bound;
  logic               dir_new;
  logic [ANGLE_W-1:0] ang_new;
  logic [DIST_W-1:0]  eff_dist;
  logic [ANGLE_W-1:0] eff_angle;

  assign item.ready       = (state == S_IDLE);
  assign accept           = item.valid && item.ready;
  assign load             = (state == S_DONE) && (!res_valid || result.ready);
  assign result.valid     = res_valid;
  assign result.angle     = res_angle;
  assign result.closest_distance = res_dist;
  assign result.closest_angle    = res_best_angle;

  // record slot lookup and conversion
  assign diff     = cur_angle - lo_angle;
  assign prod     = PROD_W'(diff) * PROD_W'(STEP_RECIP);
  assign slot_idx = prod[RECIP_SHIFT +: ANGLE_W];
  assign rec_ok   = (cur_angle >= lo_angle) &&
                    ({1'b0, slot_idx} < (ANGLE_W + 1)'(SLOTS));
  assign rec_dist = (op_status == STATUS_PHASE_FAIL) ? far_limit
                                                     : DIST_W'(op_range) + RANGE_OFFSET;
  assign do_write = (state == S_OP) && (op_action == ACT_RECORD) && rec_ok;
  assign wr_addr  = slot_idx[SLOT_W-1:0];

  // advance: reverse at or past a bound, then step
  assign at_bound = (cur_angle >= hi_angle) || (cur_angle <= lo_angle);
  assign dir_new  = sweep_down ^ at_bound;
  assign ang_new  = dir_new ? cur_angle - STEP_ANGLE : cur_angle + STEP_ANGLE;

  // slots not written since the last clear read as the fill values
  assign eff_dist  = rd_valid ? rd_slot.range_mm : fill_dist;
  assign eff_angle = rd_valid ? rd_slot.angle    : rd_nom;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_OP;
      S_OP:   state_next = S_SCAN;
      S_SCAN: if (cnt == SLOT_W'(SLOTS - 1)) state_next = S_LAST;
      S_LAST: state_next = S_DONE;
      S_DONE: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_angle  <= RST_MIN_ANGLE;
      hi_angle  <= RST_MAX_ANGLE;
      far_limit <= RST_MAX_DIST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_ANGLE: lo_angle  <= cfg_data[ANGLE_W-1:0];
        CFG_MAX_ANGLE: hi_angle  <= cfg_data[ANGLE_W-1:0];
        CFG_MAX_DIST:  far_limit <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= '{range_mm: rec_dist, angle: cur_angle};
    end
    if (state == S_SCAN) begin
      rd_slot <= mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_angle  <= RST_ANGLE;
      sweep_down <= 1'b0;
      fill_dist  <= RST_MAX_DIST;
      fill_min   <= RST_MIN_ANGLE;
      slot_valid <= '0;
      cnt        <= '0;
      cmp_en     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= (state == S_SCAN);
      if (state == S_OP) begin
        cnt <= '0;
        case (op_action)
          ACT_ADVANCE: begin
            sweep_down <= dir_new;
            cur_angle  <= ang_new;
          end
          ACT_RECORD: if (rec_ok) slot_valid[wr_addr] <= 1'b1;
          ACT_CLEAR: begin
            slot_valid <= '0;
            fill_dist  <= far_limit;
            fill_min   <= lo_angle;
          end
          default: ;
        endcase
      end
      if (state == S_SCAN) begin
        cnt      <= cnt + 1'b1;
        rd_valid <= slot_valid[cnt];
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_action <= item.action;
      op_range  <= item.raw_range;
      op_status <= item.range_status;
    end
    if (state == S_OP) begin
      nom_angle  <= (op_action == ACT_CLEAR) ? lo_angle : fill_min;
      best_dist  <= far_limit;
      best_angle <= '0;
    end
    if (state == S_SCAN) begin
      nom_angle <= nom_angle + STEP_ANGLE;
      rd_nom    <= nom_angle;
    end
    // strict less keeps the first slot on ties
    if (cmp_en && (eff_dist < best_dist)) begin
      best_dist  <= eff_dist;
      best_angle <= eff_angle;
    end
    if (load) begin
      res_angle      <= cur_angle;
      res_dist       <= best_dist;
      res_best_angle <= best_angle;
    end
  end

  `SRTC_ASSERT_NEXT(a_accept_runs_op, clk, rst, accept, state == S_OP)
  `SRTC_ASSERT_NOW(a_result_after_walk, clk, rst, $rose(res_valid), $past(state) == S_DONE)
  `SRTC_ASSERT_NEXT(a_clear_empties, clk, rst,
                    (state == S_OP) && (op_action == ACT_CLEAR), slot_valid == '0)
  `SRTC_ASSERT_NOW(a_last_compare, clk, rst, state == S_LAST, cmp_en)

endmodule

// ----- tb/sweep_range_table_closest_unit_checker.sv -----
module sweep_range_table_closest_unit_checker
  import srtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  srtc_in_if                   item,
  srtc_out_if                  result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  closest_distance;
    logic [ANGLE_W-1:0] closest_angle;
  } sweep_report_t;

  // register copies
  logic [ANGLE_W-1:0] lo_bound;
  logic [ANGLE_W-1:0] hi_bound;
  logic [DIST_W-1:0]  far_dist;

  // sweep state and range table
  logic [ANGLE_W-1:0] sweep_angle;
  logic               heading_down;
  logic [DIST_W-1:0]  range_tab [SLOTS];
  logic [ANGLE_W-1:0] slot_ang  [SLOTS];

  sweep_report_t report_q [$];
  int            fail_count = 0;

  assign errors = fail_count;

  function automatic void refill_table();
    for (int i = 0; i < SLOTS; i++) begin
      range_tab[i] = far_dist;
      slot_ang[i]  = ANGLE_W'(int'(lo_bound) + i * STEP);
    end
  endfunction

  function automatic sweep_report_t step_sweep(logic [ACTION_W-1:0] act,
                                               logic [RANGE_W-1:0] raw,
                                               logic [STATUS_W-1:0] stat);
    sweep_report_t rep;
    int            slot;
    logic [DIST_W-1:0]  best_d;
    logic [ANGLE_W-1:0] best_a;
    case (act)
      ACT_ADVANCE: begin
        // crossed bounds can make both tests true, still one flip
        if (sweep_angle >= hi_bound || sweep_angle <= lo_bound)
          heading_down = !heading_down;
        sweep_angle = heading_down ? sweep_angle - STEP_ANGLE : sweep_angle + STEP_ANGLE;
      end
      ACT_RECORD: begin
        if (sweep_angle >= lo_bound) begin
          slot = int'(sweep_angle) - int'(lo_bound);
          slot = slot / STEP;
          if (slot < SLOTS) begin
            range_tab[slot] = (stat == STATUS_PHASE_FAIL) ? far_dist
                                                          : DIST_W'(raw) + RANGE_OFFSET;
            slot_ang[slot]  = sweep_angle;
          end
        end
      end
      ACT_CLEAR: refill_table();
      default: ;
    endcase
    best_d = far_dist;
    best_a = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (range_tab[i] < best_d) begin
        best_d = range_tab[i];
        best_a = slot_ang[i];
      end
    end
    rep.angle            = sweep_angle;
    rep.closest_distance = best_d;
    rep.closest_angle    = best_a;
    return rep;
  endfunction

  always @(posedge clk) begin
    sweep_report_t want;
    if (rst) begin
      lo_bound     = RST_MIN_ANGLE;
      hi_bound     = RST_MAX_ANGLE;
      far_dist     = RST_MAX_DIST;
      sweep_angle  = RST_ANGLE;
      heading_down = 1'b0;
      refill_table();
      report_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (report_q.size() == 0) begin
          $error("result beat with no item outstanding");
          fail_count++;
        end else begin
          want = report_q.pop_front();
          if (result.angle !== want.angle) begin
            $error("angle: expected %0d, actual %0d", want.angle, result.angle);
            fail_count++;
          end
          if (result.closest_distance !== want.closest_distance) begin
            $error("closest_distance: expected %0d, actual %0d",
                   want.closest_distance, result.closest_distance);
            fail_count++;
          end
          if (result.closest_angle !== want.closest_angle) begin
            $error("closest_angle: expected %0d, actual %0d",
                   want.closest_angle, result.closest_angle);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_ANGLE: lo_bound = cfg_data[ANGLE_W-1:0];
          CFG_MAX_ANGLE: hi_bound = cfg_data[ANGLE_W-1:0];
          CFG_MAX_DIST:  far_dist = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        report_q.push_back(step_sweep(item.action, item.raw_range, item.range_status));
    end
    pending <= report_q.size();
  end

endmodule

// ----- tb/sweep_range_table_closest_unit_tb.sv -----
module sweep_range_table_closest_unit_tb;
  import srtc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;
  int                   send_idle_pct = 22;
  int                   recv_idle_pct = 52;

  srtc_in_if  item_ch ();
  srtc_out_if result_ch ();

  sweep_range_table_closest_unit dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sweep_range_table_closest_unit_checker chk (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_item(input logic [ACTION_W-1:0] act,
                           input logic [RANGE_W-1:0]  rng,
                           input logic [STATUS_W-1:0] stat);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.action       <= act;
    item_ch.raw_range    <= rng;
    item_ch.range_status <= stat;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // hold the item side until every beat in flight has come back
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(input logic [ANGLE_W-1:0] lo, input logic [ANGLE_W-1:0] hi,
                              input logic [DIST_W-1:0] far);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_ANGLE;
    cfg_data  <= CFG_W'(lo);
    @(posedge clk);
    cfg_index <= CFG_MAX_ANGLE;
    cfg_data  <= CFG_W'(hi);
    @(posedge clk);
    cfg_index <= CFG_MAX_DIST;
    cfg_data  <= CFG_W'(far);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    return ($urandom_range(3) == 0) ? RANGE_W'($urandom_range(255)) : RANGE_W'($urandom);
  endfunction

  function automatic logic [STATUS_W-1:0] pick_status();
    return ($urandom_range(5) == 0) ? STATUS_PHASE_FAIL : STATUS_W'($urandom);
  endfunction

  initial begin
    int                 sent;
    int                 pick;
    logic [ANGLE_W-1:0] lo;
    logic [ANGLE_W-1:0] hi;
    logic [ANGLE_W-1:0] tmp;
    logic [DIST_W-1:0]  far;
    logic [ACTION_W-1:0] act;

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_MIN_ANGLE;
    cfg_data             <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.action       <= ACT_ADVANCE;
    item_ch.raw_range    <= '0;
    item_ch.range_status <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: bounds 0..180, far 8190, angle 90 going up
    push_item(ACT_ADVANCE, '0, '0);
    push_item(ACT_RECORD, '0, '0);
    push_item(ACT_RECORD, '1, '1);
    push_item(ACT_RECORD, RANGE_W'(123), STATUS_PHASE_FAIL);
    push_item(ACT_UNUSED, '1, '1);
    push_item(ACT_ADVANCE, '1, STATUS_PHASE_FAIL);
    push_item(ACT_RECORD, RANGE_W'(8174), STATUS_W'(3));
    push_item(ACT_CLEAR, '0, '0);

    // crossed bounds, angle under the lower bound, cleared slots now below far
    program_regs(8'd170, 8'd20, 14'd16383);
    push_item(ACT_ADVANCE, '0, '0);
    push_item(ACT_ADVANCE, '0, '0);
    push_item(ACT_RECORD, RANGE_W'(10), STATUS_W'(1));

    // narrow window to bounce off the upper bound, far at zero
    program_regs(8'd93, 8'd105, 14'd0);
    repeat (4) push_item(ACT_ADVANCE, '0, '0);
    push_item(ACT_RECORD, RANGE_W'(10), '0);
    push_item(ACT_RECORD, '0, STATUS_PHASE_FAIL);

    // far lowered, then a clear; only strictly-below entries count
    program_regs(8'd0, 8'd180, 14'd100);
    push_item(ACT_CLEAR, '0, '0);
    push_item(ACT_RECORD, RANGE_W'(50), '0);
    push_item(ACT_RECORD, RANGE_W'(84), STATUS_W'(2));
    push_item(ACT_ADVANCE, '0, '0);
    push_item(ACT_RECORD, RANGE_W'(85), '0);

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin lo = 8'd0;   hi = 8'd180; far = 14'd16383; end
        1: begin lo = 8'd180; hi = 8'd180; far = RST_MAX_DIST; end
        2: begin lo = 8'd180; hi = 8'd0;   far = 14'd5000; end
        3: begin lo = 8'd0;   hi = 8'd180; far = 14'd0; end
        default: begin
          lo = ANGLE_W'($urandom_range(180));
          hi = ANGLE_W'($urandom_range(180));
          if (lo > hi && $urandom_range(4) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          far = $urandom_range(1) ? DIST_W'($urandom_range(16383))
                                  : DIST_W'(200 + $urandom_range(8000));
        end
      endcase
      if (ph < 5) begin
        send_idle_pct = 22;
        recv_idle_pct = 52;
      end else if (ph < 10) begin
        send_idle_pct = 52;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_regs(lo, hi, far);
      sent = 0;
      while (sent < 125) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // normal sweep rhythm: step, then take a reading
          push_item(ACT_ADVANCE, pick_range(), pick_status());
          push_item(ACT_RECORD, pick_range(), pick_status());
          sent += 2;
        end else begin
          pick = $urandom_range(99);
          act  = (pick < 35) ? ACT_ADVANCE :
                 (pick < 70) ? ACT_RECORD  :
                 (pick < 85) ? ACT_CLEAR   : ACT_UNUSED;
          push_item(act, pick_range(), pick_status());
          sent++;
        end
      end
    end

    drain();
    repeat (SLOTS + 8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
